@@ rtl/tes_pkg.sv @@
// Shared types, constants and helper functions of the timer expiry scheduler.
`timescale 1ns / 1ps

package tes_pkg;

  // Table geometry
  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int PH_W        = $clog2(SLOTS + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths of the stream payloads
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int SEL_W      = 4;
  localparam int SLOT_ID_W  = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_ID_W + 1 + TIME_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_ONCE     = 3'd0,
    CMD_PERIODIC = 3'd1,
    CMD_CANCEL   = 3'd2,
    CMD_FIRE     = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_SCHEDULED  = 3'd0,
    ST_EXPIRED    = 3'd1,
    ST_NOTHING    = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_ACTIVE = 3'd4,
    ST_CANCELLED  = 3'd5
  } status_e;

  // One result item
  typedef struct packed {
    status_e                status;
    logic [SLOT_ID_W-1:0]   slot_id;
    logic                   periodic;
    logic [TIME_W-1:0]      lateness;
    logic                   last;
  } result_t;

  // Write request towards the slot memories
  typedef struct packed {
    logic                we_dl;
    logic                we_per;
    logic [SLOT_W-1:0]   waddr;
    logic [TIME_W-1:0]   dl;
    logic [TIME_W-1:0]   per;
  } mem_wr_t;

  // Add with saturation at all ones
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  // Time past the deadline, floored at zero
  function automatic logic [TIME_W-1:0] late_of(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] dl);
    return (now >= dl) ? (now - dl) : '0;
  endfunction

endpackage

@@ rtl/tes_slot_mem.sv @@
// Deadline and period memories of the timer slots, one write and one read port.
`timescale 1ns / 1ps

module tes_slot_mem import tes_pkg::*; (
  input  logic              clk_i,
  input  mem_wr_t           wr_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output logic [TIME_W-1:0] dl_o,
  output logic [TIME_W-1:0] per_o
);

  logic [TIME_W-1:0] dl_mem  [SLOTS];
  logic [TIME_W-1:0] per_mem [SLOTS];

  // Write the addressed entries
  always_ff @(posedge clk_i) begin
    if (wr_i.we_dl) begin
      dl_mem[wr_i.waddr] <= wr_i.dl;
    end
    if (wr_i.we_per) begin
      per_mem[wr_i.waddr] <= wr_i.per;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    dl_o  <= dl_mem[rd_addr_i];
    per_o <= per_mem[rd_addr_i];
  end

endmodule

@@ rtl/timer_expiry_scheduler.sv @@
// Timer expiry scheduler: slot table with one-shot and periodic timers.
// Schedule and cancel: result goes via the pending register to the output register; fire now
// reads the slot first. Tick: one scan per expiry plus a closing scan, skipped at MAX_RESULTS;
// each expiry is a full deadline scan, a read and a write.
// Output stalls hold the sequence; the next item is taken once its last result has been registered.
// Reset clears the active bits and control state; the slot memories are not cleared.
`timescale 1ns / 1ps

module timer_expiry_scheduler import tes_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot_sel [3:0], delay_ticks [35:4], time_now [67:36], zero fill [71:68]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd [2:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slot_id [3:0], periodic [4], lateness [36:5], zero fill [39:37]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0]   m_axis_tuser,
  output logic                  m_axis_tlast
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIRE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_EXP_RD = 6'b001000,
    S_EXP_WR = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  result_t            pend_q, pend_d;
  logic               pend_v_q, pend_v_d;
  result_t            out_q;
  logic               out_v_q;
  logic [SLOTS-1:0]   active_q, active_d;
  logic [SLOTS-1:0]   done_q, done_d;
  logic [PH_W-1:0]    ph_q, ph_d;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  best_q, best_d;
  logic [TIME_W-1:0]  best_dl_q, best_dl_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0]  now_q, now_d;

  cmd_e               in_cmd;
  logic [SEL_W-1:0]   in_sel;
  logic [TIME_W-1:0]  in_delay;
  logic [TIME_W-1:0]  in_now;
  logic [SLOT_W-1:0]  sel_idx;
  logic               sel_ok;
  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               out_free;
  logic               load_out;
  logic               exp_go;
  mem_wr_t            wr;
  logic [SLOT_W-1:0]  rd_addr;
  logic [TIME_W-1:0]  rd_dl;
  logic [TIME_W-1:0]  rd_per;

  // Unpack the input transfer
  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_sel   = s_axis_tdata[SEL_W-1:0];
  assign in_delay = s_axis_tdata[SEL_W +: TIME_W];
  assign in_now   = s_axis_tdata[SEL_W + TIME_W +: TIME_W];
  assign sel_idx  = SLOT_W'(in_sel);
  assign sel_ok   = (32'(in_sel) < SLOTS) && active_q[sel_idx];

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_v_q || m_axis_tready;
  assign exp_go        = (state_q == S_EXP_WR) && (!pend_v_q || out_free);

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  tes_slot_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .dl_o      (rd_dl),
    .per_o     (rd_per)
  );

  // Sequence commands, scans and result hand-off
  always_comb begin
    logic [SLOT_W-1:0] chk_idx;
    logic              cand;
    state_d   = state_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    active_d  = active_q;
    done_d    = done_q;
    ph_d      = ph_q;
    found_d   = found_q;
    best_d    = best_q;
    best_dl_d = best_dl_q;
    cnt_d     = cnt_q;
    now_d     = now_q;
    wr        = '0;
    load_out  = 1'b0;
    rd_addr   = best_q;
    chk_idx   = SLOT_W'(ph_q - 1'b1);
    cand      = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_addr = sel_idx;
        if (s_axis_tvalid) begin
          now_d  = in_now;
          best_d = sel_idx;
          case (in_cmd)
            CMD_ONCE, CMD_PERIODIC: begin
              pend_v_d = 1'b1;
              state_d  = S_EMIT;
              if (free_found) begin
                active_d[free_idx] = 1'b1;
                wr.we_dl  = 1'b1;
                wr.we_per = 1'b1;
                wr.waddr  = free_idx;
                wr.dl     = sat_add(in_now, in_delay);
                wr.per    = (in_cmd == CMD_PERIODIC) ? in_delay : '0;
                pend_d    = '{ST_SCHEDULED, SLOT_ID_W'(free_idx), 1'b0, '0, 1'b1};
              end else begin
                pend_d    = '{ST_FULL, '0, 1'b0, '0, 1'b1};
              end
            end
            CMD_CANCEL, CMD_FIRE: begin
              if (!sel_ok) begin
                pend_d   = '{ST_NOT_ACTIVE, in_sel, 1'b0, '0, 1'b1};
                pend_v_d = 1'b1;
                state_d  = S_EMIT;
              end else if (in_cmd == CMD_CANCEL) begin
                active_d[sel_idx] = 1'b0;
                pend_d   = '{ST_CANCELLED, in_sel, 1'b0, '0, 1'b1};
                pend_v_d = 1'b1;
                state_d  = S_EMIT;
              end else begin
                state_d  = S_FIRE;
              end
            end
            CMD_TICK: begin
              done_d  = '0;
              cnt_d   = '0;
              ph_d    = '0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      // Expire the addressed slot with the data read at the transfer
      S_FIRE: begin
        wr.we_dl = (rd_per != '0);
        wr.waddr = best_q;
        wr.dl    = sat_add(now_q, rd_per);
        if (rd_per == '0) begin
          active_d[best_q] = 1'b0;
        end
        pend_d   = '{ST_EXPIRED, SLOT_ID_W'(best_q), (rd_per != '0),
                     late_of(now_q, rd_dl), 1'b1};
        pend_v_d = 1'b1;
        state_d  = S_EMIT;
      end

      // Walk the deadline memory and keep the earliest due slot
      S_SCAN: begin
        rd_addr = (32'(ph_q) < SLOTS) ? ph_q[SLOT_W-1:0] : '0;
        ph_d    = ph_q + 1'b1;
        if (ph_q != '0) begin
          cand = active_q[chk_idx] && !done_q[chk_idx] && (rd_dl <= now_q);
          if (cand && (!found_q || (rd_dl < best_dl_q))) begin
            found_d   = 1'b1;
            best_d    = chk_idx;
            best_dl_d = rd_dl;
          end
        end
        if (ph_q == PH_W'(SLOTS)) begin
          if (found_d) begin
            state_d = S_EXP_RD;
          end else begin
            if (cnt_q == '0) begin
              pend_d   = '{ST_NOTHING, '0, 1'b0, '0, 1'b1};
              pend_v_d = 1'b1;
            end else begin
              pend_d.last = 1'b1;
            end
            state_d = S_EMIT;
          end
        end
      end

      S_EXP_RD: begin
        state_d = S_EXP_WR;
      end

      // Push the previous expiry out, then re-arm or free the chosen slot
      S_EXP_WR: begin
        if (exp_go) begin
          load_out = pend_v_q;
          wr.we_dl = (rd_per != '0);
          wr.waddr = best_q;
          wr.dl    = sat_add(now_q, rd_per);
          if (rd_per == '0) begin
            active_d[best_q] = 1'b0;
          end
          done_d[best_q] = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          pend_d   = '{ST_EXPIRED, SLOT_ID_W'(best_q), (rd_per != '0),
                       late_of(now_q, best_dl_q), (cnt_d == CNT_W'(MAX_RESULTS))};
          pend_v_d = 1'b1;
          found_d  = 1'b0;
          ph_d     = '0;
          state_d  = (cnt_d == CNT_W'(MAX_RESULTS)) ? S_EMIT : S_SCAN;
        end
      end

      // Hand the final result to the output register
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      active_q <= '0;
      done_q   <= '0;
      ph_q     <= '0;
      found_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      active_q <= active_d;
      done_q   <= done_d;
      ph_q     <= ph_d;
      found_q  <= found_d;
      cnt_q    <= cnt_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    best_q    <= best_d;
    best_dl_q <= best_dl_d;
    now_q     <= now_d;
    if (load_out) begin
      out_q <= pend_q;
    end
  end

  // Pack the output transfer
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.lateness, out_q.periodic, out_q.slot_id};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

  // A result is pending only while an item is in progress
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("pending result left over in idle");

  // The output register is loaded only when it is free or being drained
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_v_q || m_axis_tready))
    else $error("output register overwritten");

  // An expired slot is marked so the next scan skips it
  a_done_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_go |=> done_q[$past(best_q)])
    else $error("expired slot not marked done");

  // The expiry count never passes its limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("expiry count out of range");

endmodule

@@ tb/timer_expiry_scheduler_tb.sv @@
// Self-checking testbench for the timer expiry scheduler: slot table predictor and stream drivers.
`timescale 1ns / 1ps

module timer_expiry_scheduler_tb import tes_pkg::*; ();

  localparam int IDLE_LIMIT   = 3000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 400;   // longer than a full sixteen-expiry tick
  localparam int RANDOM_ITEMS = 420;
  localparam int IN_FILL_W    = IN_DATA_W - 2 * TIME_W - SEL_W;

  // Timer table predictor and store of awaited results
  class expiry_scoreboard;
    logic [TIME_W-1:0] due_at [SLOTS];
    logic [TIME_W-1:0] reload [SLOTS];
    bit                armed  [SLOTS];
    result_t           awaited [$];
    int                errors;
    int                checked;
    int                expiries;
    int                refusals;

    function logic [TIME_W-1:0] add_capped(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] sum;
      sum = a + b;
      return (sum < a) ? {TIME_W{1'b1}} : sum;
    endfunction

    function void queue_result(status_e st, int s, bit per, logic [TIME_W-1:0] late, bit fin);
      result_t r;
      r.status   = st;
      r.slot_id  = SLOT_ID_W'(s);
      r.periodic = per;
      r.lateness = late;
      r.last     = fin;
      awaited = {awaited, r};
    endfunction

    // Expire one slot: free a one-shot, re-arm a periodic one
    function bit retire(int s, logic [TIME_W-1:0] now, output logic [TIME_W-1:0] late);
      expiries++;
      late = (now >= due_at[s]) ? now - due_at[s] : '0;
      if (reload[s] != '0) begin
        due_at[s] = add_capped(now, reload[s]);
        return 1'b1;
      end
      armed[s] = 1'b0;
      return 1'b0;
    endfunction

    // Work out the results of one accepted command
    function void note_input(logic [CMD_W-1:0] code, logic [SEL_W-1:0] sel,
                             logic [TIME_W-1:0] dly, logic [TIME_W-1:0] now);
      bit                hit [SLOTS];
      bit                found;
      bit                per;
      int                best;
      int                count;
      logic [TIME_W-1:0] late;
      result_t           r;
      case (code)
        CMD_ONCE, CMD_PERIODIC: begin
          found = 1'b0;
          for (int s = 0; s < SLOTS && !found; s++) begin
            if (!armed[s]) begin
              armed[s]  = 1'b1;
              due_at[s] = add_capped(now, dly);
              reload[s] = (code == CMD_PERIODIC) ? dly : '0;
              queue_result(ST_SCHEDULED, s, 1'b0, '0, 1'b1);
              found = 1'b1;
            end
          end
          if (!found) begin
            refusals++;
            queue_result(ST_FULL, 0, 1'b0, '0, 1'b1);
          end
        end
        CMD_CANCEL, CMD_FIRE: begin
          if (!armed[sel]) begin
            queue_result(ST_NOT_ACTIVE, sel, 1'b0, '0, 1'b1);
          end else if (code == CMD_CANCEL) begin
            armed[sel] = 1'b0;
            queue_result(ST_CANCELLED, sel, 1'b0, '0, 1'b1);
          end else begin
            per = retire(sel, now, late);
            queue_result(ST_EXPIRED, sel, per, late, 1'b1);
          end
        end
        CMD_TICK: begin
          foreach (hit[s]) hit[s] = armed[s] && (due_at[s] <= now);
          count = 0;
          // Earliest deadline first, lower slot on a tie
          while (count < MAX_RESULTS) begin
            best = -1;
            for (int s = 0; s < SLOTS; s++)
              if (hit[s] && (best < 0 || due_at[s] < due_at[best])) best = s;
            if (best < 0) break;
            hit[best] = 1'b0;
            per = retire(best, now, late);
            queue_result(ST_EXPIRED, best, per, late, 1'b0);
            count++;
          end
          if (count == 0) begin
            queue_result(ST_NOTHING, 0, 1'b0, '0, 1'b1);
          end else begin
            r = awaited.pop_back();
            r.last = 1'b1;
            awaited = {awaited, r};
          end
        end
        default: ;  // unused codes leave the table alone
      endcase
    endfunction

    function void compare_field(string field, logic [TIME_W-1:0] want,
                                logic [TIME_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_ID_W-1:0] sid, logic per,
                               logic [TIME_W-1:0] late, logic fin);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d slot %0d", st, sid);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("status", want.status, st);
      compare_field("slot_id", want.slot_id, sid);
      compare_field("periodic", want.periodic, per);
      compare_field("lateness", want.lateness, late);
      compare_field("last", want.last, fin);
    endfunction

    function logic [SEL_W-1:0] pick_armed();
      int live [$];
      foreach (armed[s]) if (armed[s]) live = {live, s};
      if (live.size() == 0) return SEL_W'($urandom_range(0, SLOTS - 1));
      return SEL_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  expiry_scoreboard sb = new();
  bit               no_gaps;
  int               idle_cycles;
  int               commands_sent;
  logic [TIME_W-1:0] clock_now;

  timer_expiry_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Predict on every input transfer, check every output transfer, count idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[SLOT_ID_W-1:0], m_axis_tdata[SLOT_ID_W],
                        m_axis_tdata[SLOT_ID_W+1 +: TIME_W], m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tuser, s_axis_tdata[SEL_W-1:0], s_axis_tdata[SEL_W +: TIME_W],
                      s_axis_tdata[SEL_W+TIME_W +: TIME_W]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $error("no transfer for %0d cycles, %0d results still awaited", IDLE_LIMIT,
           sb.awaited.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Accept results after a random stall per result
  initial begin : result_sink
    int hold;
    m_axis_tready = 1'b0;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 13);
      @(negedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Present one command after a random gap and hold it until the transfer
  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [SEL_W-1:0] sel,
                          input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {{IN_FILL_W{1'b0}}, now, dly, sel};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin : stimulus
    int                pick;
    logic [CMD_W-1:0]  code;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] stamp;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    no_gaps       = 1'b0;
    commands_sent = 0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, inactive slots, zero and saturating delays
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_CANCEL, 4'd5, '0, '0);
    send_cmd(CMD_FIRE, 4'd15, '1, '1);
    send_cmd(CMD_ONCE, '0, '0, 32'd100);
    send_cmd(CMD_PERIODIC, 4'hF, '0, 32'd100);           // zero period acts as one-shot
    send_cmd(CMD_PERIODIC, '0, 32'd10, 32'd100);
    send_cmd(CMD_ONCE, '0, '1, 32'hFFFF_FFF0);            // deadline saturates
    send_cmd(CMD_PERIODIC, '0, '1, 32'd5);
    send_cmd(CMD_FIRE, 4'd2, '0, 32'd50);                 // fired ahead of its deadline
    send_cmd(3'd5, 4'hA, 32'h5555_5555, 32'hAAAA_AAAA);   // unused codes are dropped
    send_cmd(3'd7, 4'h5, 32'hAAAA_AAAA, 32'h5555_5555);
    send_cmd(CMD_TICK, '0, '0, 32'd200);                  // tie between two slots
    // Fill the table, then overflow it
    for (int i = 0; i < 14; i++)
      send_cmd((i % 3 == 0) ? CMD_PERIODIC : CMD_ONCE, '0, $urandom_range(1, 1000), 32'd300);
    send_cmd(CMD_TICK, '0, '0, '1);                       // every slot due at once
    send_cmd(CMD_TICK, '0, '0, '1);                       // saturated re-arms due again

    // Random: mostly a running clock with sensible timers, some noise on the time field
    clock_now = 32'd1000;
    while (commands_sent < RANDOM_ITEMS) begin
      if (commands_sent % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick  = $urandom_range(0, 99);
      stamp = ($urandom_range(0, 15) == 0) ? $urandom : clock_now;
      if (pick < 4) begin
        code = CMD_W'($urandom_range(5, 7));
        send_cmd(code, SEL_W'($urandom), $urandom, $urandom);
        commands_sent--;
      end else if (pick < 32) begin
        case ($urandom_range(0, 9))
          7, 8:    dly = $urandom;
          9:       dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: dly = $urandom_range(0, 60);
        endcase
        send_cmd($urandom_range(0, 1) ? CMD_PERIODIC : CMD_ONCE, SEL_W'($urandom), dly, stamp);
      end else if (pick < 48) begin
        send_cmd(CMD_CANCEL, ($urandom_range(0, 3) == 0) ? SEL_W'($urandom) : sb.pick_armed(),
                 $urandom, stamp);
      end else if (pick < 62) begin
        send_cmd(CMD_FIRE, ($urandom_range(0, 3) == 0) ? SEL_W'($urandom) : sb.pick_armed(),
                 $urandom, stamp);
      end else begin
        clock_now = clock_now + $urandom_range(0, 40);
        send_cmd(CMD_TICK, SEL_W'($urandom), $urandom,
                 (stamp == clock_now - 1) ? stamp : clock_now);
      end
      commands_sent++;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d random commands after the directed set: %0d results checked,",
             commands_sent, sb.checked);
    $display("including %0d expiries and %0d refusals on a full table.", sb.expiries,
             sb.refusals);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tes_pkg.sv
rtl/tes_slot_mem.sv
rtl/timer_expiry_scheduler.sv
tb/timer_expiry_scheduler_tb.sv
